>>> sv/gjc_pkg.sv
package gjc_pkg;

  // frame size limits
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;

  // column and row position widths
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // widths that can hold the frame size itself
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  // configuration data width and reset sizes
  localparam int CFG_W           = 8;
  localparam int GRID_WIDTH_RST  = 100;
  localparam int GRID_HEIGHT_RST = 100;

  // class counters
  localparam int CNT_W   = 15;
  localparam int NUM_CLS = 4;
  localparam int INC_W   = 2;

  // class slots
  localparam int CLS_CROSS = 0;
  localparam int CLS_TEE   = 1;
  localparam int CLS_TURN  = 2;
  localparam int CLS_DEAD  = 3;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [NUM_CLS-1:0] cls_vec_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // per-request class increments from the scan stage
  typedef struct packed {
    logic                          valid;
    logic                          last;
    logic [NUM_CLS-1:0][INC_W-1:0] inc;
  } gjc_inc_t;

endpackage

>>> sv/gjc_line_mem.sv
module gjc_line_mem
  import gjc_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [1:0]       wr_data,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output logic [1:0]       rd_data_r
);

  // bit0 last row seen in the column, bit1 the row above it
  logic [1:0] line_mem [MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
  end

  // registered read, write-first on the same address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= line_mem[rd_addr];
      end
    end
  end

endmodule

>>> sv/gjc_window.sv
module gjc_window
  import gjc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_pixel,
  input  logic             out_busy,
  output logic             mem_wr_en,
  output logic [COL_W-1:0] mem_wr_addr,
  output logic [1:0]       mem_wr_data,
  output logic             mem_rd_en,
  output logic [COL_W-1:0] mem_rd_addr,
  input  logic [1:0]       mem_rd_data,
  output gjc_inc_t         inc_r
);

  localparam int SZ_W = 16;

  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [1:0]       cur_r;      // line entry of the current column
  logic             up_left_r;  // previous row, one column to the left
  logic             p1_r;       // current row, one column to the left
  logic             p2_r;       // current row, two columns to the left

  logic             accept;
  logic             col_last;
  logic             row_last;
  logic             frame_last;
  logic             right_up;
  cls_vec_t         cls_above;
  cls_vec_t         cls_prev;
  cls_vec_t         cls_cur;
  logic [NUM_CLS-1:0][INC_W-1:0] inc_nxt;
  logic [WID_W:0]   ahead_sum;

  function automatic logic [SZ_W-1:0] clamp_size(logic [CFG_W-1:0] v, int unsigned maxv);
    logic [SZ_W-1:0] res;
    if (v < CFG_W'(2)) begin
      res = SZ_W'(2);
    end else if (32'(v) > maxv) begin
      res = SZ_W'(maxv);
    end else begin
      res = SZ_W'(v);
    end
    return res;
  endfunction

  function automatic cls_vec_t classify(logic up, logic down, logic left, logic right);
    logic [2:0] n;
    cls_vec_t   res;
    n   = 3'(up) + 3'(down) + 3'(left) + 3'(right);
    res = '0;
    case (n)
      3'd4: res[CLS_CROSS] = 1'b1;
      3'd3: res[CLS_TEE]   = 1'b1;
      3'd2: res[CLS_TURN]  = !(up && down) && !(left && right);
      3'd1: res[CLS_DEAD]  = 1'b1;
      default: res = '0;
    endcase
    return res;
  endfunction

  // scan position
  assign col_last   = (WID_W'(col_r) == width_r - WID_W'(1));
  assign row_last   = (HGT_W'(row_r) == height_r - HGT_W'(1));
  assign frame_last = col_last && row_last;

  // hold the frame's last pixel while the previous result waits
  assign in_tready = !(frame_last && out_busy);
  assign accept    = in_tvalid && in_tready;

  // cell above the incoming pixel
  assign right_up  = !col_last && mem_rd_data[0];
  assign cls_above = ((row_r != '0) && cur_r[0])
                   ? classify((row_r >= ROW_W'(2)) && cur_r[1], in_pixel, up_left_r, right_up)
                   : '0;

  // last row: left neighbour of the pixel, and the pixel itself at row end
  assign cls_prev = (row_last && (col_r != '0) && p1_r)
                  ? classify(up_left_r, 1'b0, p2_r, in_pixel) : '0;
  assign cls_cur  = (frame_last && in_pixel)
                  ? classify(cur_r[0], 1'b0, p1_r, 1'b0) : '0;

  // per-class increments
  always_comb begin
    for (int k = 0; k < NUM_CLS; k++) begin
      inc_nxt[k] = INC_W'(cls_above[k]) + INC_W'(cls_prev[k]) + INC_W'(cls_cur[k]);
    end
  end

  // prefetch two columns ahead, wrapping into the next row
  always_comb begin
    ahead_sum = (WID_W + 1)'(col_r) + (WID_W + 1)'(2);
    if (ahead_sum >= (WID_W + 1)'(width_r)) begin
      ahead_sum = ahead_sum - (WID_W + 1)'(width_r);
    end
  end

  // line memory requests
  assign mem_wr_en   = accept;
  assign mem_wr_addr = col_r;
  assign mem_wr_data = {cur_r[0], in_pixel};
  assign mem_rd_en   = accept;
  assign mem_rd_addr = COL_W'(ahead_sum);

  // size registers, scan position and neighbour window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WID_W'(clamp_size(CFG_W'(GRID_WIDTH_RST), MAX_WIDTH));
      height_r  <= HGT_W'(clamp_size(CFG_W'(GRID_HEIGHT_RST), MAX_HEIGHT));
      col_r     <= '0;
      row_r     <= '0;
      up_left_r <= 1'b0;
      p1_r      <= 1'b0;
      p2_r      <= 1'b0;
      inc_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_WIDTH:  width_r  <= WID_W'(clamp_size(cfg_wdata, MAX_WIDTH));
        REG_GRID_HEIGHT: height_r <= HGT_W'(clamp_size(cfg_wdata, MAX_HEIGHT));
        default: ;
      endcase
      col_r     <= '0;
      row_r     <= '0;
      up_left_r <= 1'b0;
      p1_r      <= 1'b0;
      p2_r      <= 1'b0;
      inc_r     <= '0;
    end else begin
      inc_r.valid <= accept;
      inc_r.last  <= frame_last;
      inc_r.inc   <= inc_nxt;
      if (accept) begin
        cur_r <= mem_rd_data;
        if (col_last) begin
          col_r     <= '0;
          row_r     <= row_last ? '0 : row_r + ROW_W'(1);
          up_left_r <= 1'b0;
          p1_r      <= 1'b0;
          p2_r      <= 1'b0;
        end else begin
          col_r     <= col_r + COL_W'(1);
          up_left_r <= cur_r[0];
          p1_r      <= in_pixel;
          p2_r      <= p1_r;
        end
      end
    end
  end

  // frame end returns the scan to the origin
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_last |=> (col_r == '0) && (row_r == '0))
    else $error("scan did not return to origin after frame end");

  // scan position stays inside the frame
  assert property (@(posedge clk) disable iff (!rst_n)
    (WID_W'(col_r) < width_r) && (HGT_W'(row_r) < height_r))
    else $error("scan position outside frame");

endmodule

>>> sv/gjc_count.sv
module gjc_count
  import gjc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     clear,
  input  gjc_inc_t inc,
  input  logic     out_tready,
  output logic     out_valid_r,
  output cnt_t     out_cnt_r [NUM_CLS],
  output logic     out_busy
);

  cnt_t cnt_r   [NUM_CLS];
  cnt_t sum_nxt [NUM_CLS];

  assign out_busy = out_valid_r && !out_tready;

  // saturating add of the increments
  always_comb begin
    for (int k = 0; k < NUM_CLS; k++) begin
      logic [CNT_W:0] s;
      s = {1'b0, cnt_r[k]} + (CNT_W + 1)'(inc.inc[k]);
      sum_nxt[k] = s[CNT_W] ? '1 : s[CNT_W-1:0];
    end
  end

  // class counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_CLS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      // a new frame result wins over the handshake that retires the old one
      if (inc.valid && inc.last && !clear) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (clear) begin
        for (int k = 0; k < NUM_CLS; k++) begin
          cnt_r[k] <= '0;
        end
      end else if (inc.valid) begin
        if (inc.last) begin
          for (int k = 0; k < NUM_CLS; k++) begin
            out_cnt_r[k] <= sum_nxt[k];
            cnt_r[k]     <= '0;
          end
        end else begin
          for (int k = 0; k < NUM_CLS; k++) begin
            cnt_r[k] <= sum_nxt[k];
          end
        end
      end
    end
  end

  // a frame result never lands on one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    inc.valid && inc.last && !clear |-> !out_valid_r || out_tready)
    else $error("frame result overwrote a pending result");

  // frame end always produces a result
  assert property (@(posedge clk) disable iff (!rst_n)
    inc.valid && inc.last && !clear |=> out_valid_r)
    else $error("frame end without result");

endmodule

>>> sv/grid_junction_classifier.sv
// Junction classifier for a binary road map streamed one pixel per request in
// raster order, grid_width columns by grid_height rows (each clamped to 2..128).
// Every road cell counts its road 4-neighbours (outside the grid is empty) and
// is tallied as crossing, T-junction, perpendicular turn or dead end. One pixel
// is accepted per clock; each pixel costs one write and one read of the
// single-port-pair line memory, which fixes that rate. The frame's four counts
// leave as one result via the increment and result registers once the last pixel
// is accepted, and the counters restart for the next frame. The input stalls only
// on a frame's last pixel while the previous frame's result waits. Writing either
// size register restarts the frame. The line memory needs no clearing after reset.
module grid_junction_classifier
  import gjc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [0] pixel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata   // [14:0] crossings, [29:15] t_junctions,
                                       // [44:30] turns, [59:45] dead_ends
);

  logic             mem_wr_en;
  logic [COL_W-1:0] mem_wr_addr;
  logic [1:0]       mem_wr_data;
  logic             mem_rd_en;
  logic [COL_W-1:0] mem_rd_addr;
  logic [1:0]       mem_rd_data;
  gjc_inc_t         inc;
  logic             out_busy;
  cnt_t             out_cnt [NUM_CLS];

  // line store
  gjc_line_mem u_line_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_data_r (mem_rd_data)
  );

  // scan, neighbour window and classification
  gjc_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_reg_t'(cfg_addr)),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_pixel    (in_tdata[0]),
    .out_busy    (out_busy),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .inc_r       (inc)
  );

  // class counters and result register
  gjc_count u_count (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (cfg_we),
    .inc         (inc),
    .out_tready  (out_tready),
    .out_valid_r (out_tvalid),
    .out_cnt_r   (out_cnt),
    .out_busy    (out_busy)
  );

  // result packing
  assign out_tdata = {4'b0000, out_cnt[CLS_DEAD], out_cnt[CLS_TURN],
                      out_cnt[CLS_TEE], out_cnt[CLS_CROSS]};

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gjc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;

  // one frame's junction counts, laid out as on out_tdata
  typedef struct packed {
    cnt_t dead_ends;
    cnt_t turns;
    cnt_t t_junctions;
    cnt_t crossings;
  } junction_counts_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;   // [0] pixel
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [63:0]      out_tdata;       // [14:0] crossings, [29:15] t_junctions,
                                     // [44:30] turns, [59:45] dead_ends

  grid_junction_classifier uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stimulus and scoreboard state
  logic [7:0]       pixel_q[$];
  junction_counts_t frame_counts_q[$];
  logic             in_fire = 1'b0;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               mismatches = 0;
  int               cycle_count = 0;
  junction_counts_t exp_counts;
  junction_counts_t got_counts;

  // shadow of the block: size registers, line store, window, raster position
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [1:0]       line_bits [0:MAX_WIDTH-1];
  logic [5:0]       above_bits;
  int               col_pos;
  int               row_pos;
  cnt_t             class_cnt [NUM_CLS];

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void restart_frame();
    above_bits = '0;
    col_pos = 0;
    row_pos = 0;
    for (int k = 0; k < NUM_CLS; k++) class_cnt[k] = '0;
  endfunction

  function automatic void bump_class(int k);
    if (class_cnt[k] != '1) class_cnt[k] = class_cnt[k] + 1'b1;
  endfunction

  // classify one road cell from its four neighbours
  function automatic void tally_cell(logic up, logic down, logic left, logic right);
    int n;
    n = up + down + left + right;
    case (n)
      4: bump_class(CLS_CROSS);
      3: bump_class(CLS_TEE);
      2: if (!(up && down) && !(left && right)) bump_class(CLS_TURN);
      1: bump_class(CLS_DEAD);
      default: ;
    endcase
  endfunction

  // one accepted pixel: classify the cells it completes, push frame totals at frame end
  function automatic void advance_raster(logic p);
    int               w;
    int               h;
    logic [1:0]       old;
    logic             up;
    logic             left;
    logic             right;
    junction_counts_t totals;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    old = line_bits[col_pos];

    // cell above the incoming pixel
    if (row_pos >= 1 && old[0]) begin
      up = (row_pos >= 2) ? old[1] : 1'b0;
      left = (col_pos > 0) ? above_bits[0] : 1'b0;
      right = (col_pos + 1 < w) ? line_bits[col_pos + 1][0] : 1'b0;
      tally_cell(up, p, left, right);
    end
    above_bits = {above_bits[4:0], old[0]};
    line_bits[col_pos] = {old[0], p};

    // bottom row has no lower neighbour
    if (row_pos == h - 1) begin
      if (col_pos >= 1 && line_bits[col_pos - 1][0]) begin
        up = line_bits[col_pos - 1][1];
        left = (col_pos >= 2) ? line_bits[col_pos - 2][0] : 1'b0;
        tally_cell(up, 1'b0, left, p);
      end
      if (col_pos == w - 1 && p) begin
        tally_cell(line_bits[col_pos][1], 1'b0, line_bits[col_pos - 1][0], 1'b0);
      end
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      above_bits = '0;
      row_pos++;
      if (row_pos >= h) begin
        totals.crossings = class_cnt[CLS_CROSS];
        totals.t_junctions = class_cnt[CLS_TEE];
        totals.turns = class_cnt[CLS_TURN];
        totals.dead_ends = class_cnt[CLS_DEAD];
        frame_counts_q.push_back(totals);
        restart_frame();
      end
    end
  endfunction

  function automatic void check_count(string fname, cnt_t e, cnt_t a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", fname, e, a);
      mismatches++;
    end
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= pixel_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // monitor: track writes and accepted pixels, check results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire = 1'b0;
      width_reg = CFG_W'(GRID_WIDTH_RST);
      height_reg = CFG_W'(GRID_HEIGHT_RST);
      for (int i = 0; i < MAX_WIDTH; i++) line_bits[i] = '0;
      restart_frame();
    end else begin
      in_fire = in_tvalid && in_tready;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_GRID_WIDTH:  width_reg = cfg_wdata;
          REG_GRID_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
        restart_frame();
      end
      if (in_fire) advance_raster(in_tdata[0]);
      if (out_tvalid && out_tready) begin
        if (frame_counts_q.size() == 0) begin
          $error("result with no frame pending: %h", out_tdata);
          mismatches++;
        end else begin
          exp_counts = frame_counts_q.pop_front();
          got_counts = out_tdata[59:0];
          check_count("crossings", exp_counts.crossings, got_counts.crossings);
          check_count("t_junctions", exp_counts.t_junctions, got_counts.t_junctions);
          check_count("turns", exp_counts.turns, got_counts.turns);
          check_count("dead_ends", exp_counts.dead_ends, got_counts.dead_ends);
          if (out_tdata[63:60] !== 4'b0) begin
            $error("padding: expected 0, got %h", out_tdata[63:60]);
            mismatches++;
          end
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // pixel with junk in the unused upper bits
  task automatic push_pixel(logic p);
    pixel_q.push_back({7'($urandom), p});
  endtask

  task automatic push_pattern(logic [15:0] bits, int n);
    for (int i = 0; i < n; i++) push_pixel(bits[i]);
  endtask

  task automatic push_random(int n, int density);
    for (int i = 0; i < n; i++) push_pixel($urandom_range(99) < density);
  endtask

  // wait until every pixel is taken and every frame result is back
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_q.size() != 0 || in_tvalid || frame_counts_q.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // resize only once the block has gone quiet
  task automatic set_size(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_GRID_WIDTH, wv);
    write_reg(REG_GRID_HEIGHT, hv);
  endtask

  initial begin
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    int               area;
    int               frames;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: full 3x3, a T with a straight stem, clamped 2x2, then a cut-off frame
    set_size(8'd3, 8'd3);
    push_pattern(16'h01FF, 9);
    push_pattern(16'h0097, 9);
    set_size(8'd0, 8'd1);
    push_pattern(16'h0007, 4);
    drain();
    push_pattern(16'h0007, 3);

    // random: four idling phases, a few frame sizes each
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 87 : (ph == 3) ? 13 : 0;
      stall_pct = (ph == 2) ? 87 : (ph == 3) ? 13 : 0;
      for (int k = 0; k < 4; k++) begin
        if (k == 0) begin
          case (ph)
            0: begin wv = 8'd255; hv = 8'd2; end
            1: begin wv = 8'd1;   hv = 8'd3; end
            2: begin wv = 8'd2;   hv = 8'd1; end
            default: begin wv = 8'd0; hv = 8'd0; end
          endcase
        end else begin
          wv = $urandom_range(2, 6);
          hv = $urandom_range(2, 6);
        end
        set_size(wv, hv);
        area = clamp_dim(wv, MAX_WIDTH) * clamp_dim(hv, MAX_HEIGHT);
        frames = (area >= 16) ? 1 : 16 / area;
        for (int f = 0; f < frames; f++) begin
          push_random(area, (area > 1000) ? 50 : $urandom_range(20, 100));
          // occasionally hold the sender until the results are all back
          if ($urandom_range(3) == 0) drain();
        end
        // sometimes leave a frame unfinished so the next resize restarts it
        if (area < 40 && $urandom_range(2) == 0) push_random($urandom_range(1, area - 1), 60);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
